// ===== hw/rtl/irpde_pkg.sv =====
// Shared types and constants for the infrared pulse-distance encoder.
// Holds the phase enum, register indexes, reset timings and the
// controller/datapath command and status structs. No dependencies.
package irpde_pkg;

    localparam int PAYLOAD_W = 48;
    localparam int COUNT_W   = 6;
    localparam int DUR_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int MAX_BITS  = 48;

    localparam logic [COUNT_W-1:0] PAYLOAD_BITS = COUNT_W'(PAYLOAD_W);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BITS,
        PH_TRAILER
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_MARK  = 3'd0,
        REG_HEADER_SPACE = 3'd1,
        REG_ONE_MARK     = 3'd2,
        REG_ONE_SPACE    = 3'd3,
        REG_ZERO_MARK    = 3'd4,
        REG_ZERO_SPACE   = 3'd5,
        REG_TRAILER_MARK = 3'd6
    } reg_idx_t;

    localparam logic [DUR_W-1:0] RST_HEADER_MARK  = 16'd9000;
    localparam logic [DUR_W-1:0] RST_HEADER_SPACE = 16'd4500;
    localparam logic [DUR_W-1:0] RST_ONE_MARK     = 16'd560;
    localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 16'd1690;
    localparam logic [DUR_W-1:0] RST_ZERO_MARK    = 16'd560;
    localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 16'd560;
    localparam logic [DUR_W-1:0] RST_TRAILER_MARK = 16'd560;

    typedef struct packed {
        logic load_frame;
        logic emit_header;
        logic emit_bit;
        logic emit_trailer;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic bits_zero;
        logic bits_one;
        logic trailer_off;
    } status_t;

endpackage

// ===== hw/rtl/ir_pulse_distance_encoder.sv =====
// Infrared pulse-distance / pulse-width frame encoder, top level.
// The frame is taken in the idle phase; the header phase then registers the header pair once the output word is free.
// Throughput: one pair per cycle while m_ready holds; a frame is taken in the idle phase, then pairs
// go out in order: the header, one per bit, and the trailer unless its mark is zero.
// Reset (aresetn, synchronous, active low) restores the default timings and idles.
// Depends on irpde_pkg, irpde_ctrl and irpde_datapath.
module ir_pulse_distance_encoder #(
    parameter int MAX_BITS = irpde_pkg::MAX_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Timing register write port
    input  logic                                  cfg_wr_en,
    input  logic [irpde_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [irpde_pkg::DUR_W-1:0]           cfg_wdata,
    // Frame input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [irpde_pkg::PAYLOAD_W-1:0]       s_payload,
    input  logic [irpde_pkg::COUNT_W-1:0]         s_bit_count,
    // Mark/space pair output
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [irpde_pkg::DUR_W-1:0]           m_mark_us,
    output logic [irpde_pkg::DUR_W-1:0]           m_space_us,
    output logic                                  m_last_pair
);

    // The sequencer accepts a frame only when idle; the datapath latches the
    // aligned payload and count. Each following phase pushes one pair into
    // the output word register whenever it is empty or being drained, so a
    // waiting consumer stalls the sequencer but never loses a word. The last
    // pair of a frame may still sit in the output register while the next
    // frame is being taken.
    irpde_pkg::cmd_t    cmd;
    irpde_pkg::status_t status;

    irpde_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    irpde_datapath #(
        .MAX_BITS (MAX_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_payload   (s_payload),
        .s_bit_count (s_bit_count),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_mark_us   (m_mark_us),
        .m_space_us  (m_space_us),
        .m_last_pair (m_last_pair),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ===== hw/rtl/irpde_ctrl.sv =====
// Frame sequencer for the infrared pulse-distance encoder.
// Walks header, bit and trailer phases; depends on irpde_pkg.
module irpde_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  irpde_pkg::status_t status,
    output irpde_pkg::cmd_t    cmd
);

    irpde_pkg::phase_t phase_reg;
    irpde_pkg::phase_t phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= irpde_pkg::PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            irpde_pkg::PH_IDLE: begin
                if (s_valid) begin
                    phase_next = irpde_pkg::PH_HEADER;
                end
            end
            irpde_pkg::PH_HEADER: begin
                if (status.out_free) begin
                    priority if (!status.bits_zero) begin
                        phase_next = irpde_pkg::PH_BITS;
                    end else if (!status.trailer_off) begin
                        phase_next = irpde_pkg::PH_TRAILER;
                    end else begin
                        phase_next = irpde_pkg::PH_IDLE;
                    end
                end
            end
            irpde_pkg::PH_BITS: begin
                if (status.out_free && status.bits_one) begin
                    phase_next = status.trailer_off ? irpde_pkg::PH_IDLE
                                                    : irpde_pkg::PH_TRAILER;
                end
            end
            irpde_pkg::PH_TRAILER: begin
                if (status.out_free) begin
                    phase_next = irpde_pkg::PH_IDLE;
                end
            end
            default: phase_next = irpde_pkg::PH_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (phase_reg)
            irpde_pkg::PH_IDLE: begin
                s_ready        = 1'b1;
                cmd.load_frame = s_valid;
            end
            irpde_pkg::PH_HEADER:  cmd.emit_header  = status.out_free;
            irpde_pkg::PH_BITS:    cmd.emit_bit     = status.out_free;
            irpde_pkg::PH_TRAILER: cmd.emit_trailer = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/irpde_datapath.sv =====
// Datapath of the infrared pulse-distance encoder: timing registers,
// payload shifter, bit counter and output word register. Uses irpde_pkg.
module irpde_datapath #(
    parameter int MAX_BITS = irpde_pkg::MAX_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [irpde_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [irpde_pkg::DUR_W-1:0]           cfg_wdata,
    input  logic [irpde_pkg::PAYLOAD_W-1:0]       s_payload,
    input  logic [irpde_pkg::COUNT_W-1:0]         s_bit_count,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [irpde_pkg::DUR_W-1:0]           m_mark_us,
    output logic [irpde_pkg::DUR_W-1:0]           m_space_us,
    output logic                                  m_last_pair,
    input  irpde_pkg::cmd_t                       cmd,
    output irpde_pkg::status_t                    status
);

    // Effective ceiling on the bit count: the parameter limit and the word width.
    localparam int BIT_LIMIT_INT = (MAX_BITS < irpde_pkg::PAYLOAD_W) ? MAX_BITS
                                                                      : irpde_pkg::PAYLOAD_W;
    localparam logic [irpde_pkg::COUNT_W-1:0] BIT_LIMIT = irpde_pkg::COUNT_W'(BIT_LIMIT_INT);

    logic [irpde_pkg::DUR_W-1:0] hdr_mark_reg, hdr_space_reg;
    logic [irpde_pkg::DUR_W-1:0] one_mark_reg, one_space_reg;
    logic [irpde_pkg::DUR_W-1:0] zero_mark_reg, zero_space_reg;
    logic [irpde_pkg::DUR_W-1:0] trl_mark_reg;

    logic [irpde_pkg::PAYLOAD_W-1:0] shift_reg;
    logic [irpde_pkg::COUNT_W-1:0]   bits_left_reg;
    logic [irpde_pkg::COUNT_W-1:0]   count_sat;
    logic [irpde_pkg::COUNT_W-1:0]   shift_amt;

    logic                        out_valid_reg;
    logic [irpde_pkg::DUR_W-1:0] mark_reg, mark_next;
    logic [irpde_pkg::DUR_W-1:0] space_reg, space_next;
    logic                        last_reg, last_next;
    logic                        emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_mark_reg   <= irpde_pkg::RST_HEADER_MARK;
            hdr_space_reg  <= irpde_pkg::RST_HEADER_SPACE;
            one_mark_reg   <= irpde_pkg::RST_ONE_MARK;
            one_space_reg  <= irpde_pkg::RST_ONE_SPACE;
            zero_mark_reg  <= irpde_pkg::RST_ZERO_MARK;
            zero_space_reg <= irpde_pkg::RST_ZERO_SPACE;
            trl_mark_reg   <= irpde_pkg::RST_TRAILER_MARK;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                irpde_pkg::REG_HEADER_MARK:  hdr_mark_reg   <= cfg_wdata;
                irpde_pkg::REG_HEADER_SPACE: hdr_space_reg  <= cfg_wdata;
                irpde_pkg::REG_ONE_MARK:     one_mark_reg   <= cfg_wdata;
                irpde_pkg::REG_ONE_SPACE:    one_space_reg  <= cfg_wdata;
                irpde_pkg::REG_ZERO_MARK:    zero_mark_reg  <= cfg_wdata;
                irpde_pkg::REG_ZERO_SPACE:   zero_space_reg <= cfg_wdata;
                irpde_pkg::REG_TRAILER_MARK: trl_mark_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp the count, then align so the first bit to send sits at the top.
    assign count_sat = (s_bit_count > BIT_LIMIT) ? BIT_LIMIT : s_bit_count;
    assign shift_amt = irpde_pkg::PAYLOAD_BITS - count_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_left_reg <= '0;
        end else if (cmd.load_frame) begin
            bits_left_reg <= count_sat;
        end else if (cmd.emit_bit) begin
            bits_left_reg <= bits_left_reg - irpde_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_frame) begin
            shift_reg <= s_payload << shift_amt;
        end else if (cmd.emit_bit) begin
            shift_reg <= {shift_reg[irpde_pkg::PAYLOAD_W-2:0], 1'b0};
        end
    end

    assign emit = cmd.emit_header | cmd.emit_bit | cmd.emit_trailer;

    always_comb begin
        mark_next  = mark_reg;
        space_next = space_reg;
        last_next  = last_reg;
        priority if (cmd.emit_header) begin
            mark_next  = hdr_mark_reg;
            space_next = hdr_space_reg;
            last_next  = status.bits_zero & status.trailer_off;
        end else if (cmd.emit_bit) begin
            mark_next  = shift_reg[irpde_pkg::PAYLOAD_W-1] ? one_mark_reg : zero_mark_reg;
            space_next = shift_reg[irpde_pkg::PAYLOAD_W-1] ? one_space_reg : zero_space_reg;
            last_next  = status.bits_one & status.trailer_off;
        end else if (cmd.emit_trailer) begin
            mark_next  = trl_mark_reg;
            space_next = '0;
            last_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        mark_reg  <= mark_next;
        space_reg <= space_next;
        last_reg  <= last_next;
    end

    assign status.out_free    = ~out_valid_reg | m_ready;
    assign status.bits_zero   = (bits_left_reg == '0);
    assign status.bits_one    = (bits_left_reg == irpde_pkg::COUNT_W'(1));
    assign status.trailer_off = (trl_mark_reg == '0);

    assign m_valid     = out_valid_reg;
    assign m_mark_us   = mark_reg;
    assign m_space_us  = space_reg;
    assign m_last_pair = last_reg;

endmodule

// ===== sim/ir_pulse_distance_encoder_tb.sv =====
// Self-checking testbench for ir_pulse_distance_encoder: frames in, mark/space pairs out.
// Predicts every pair from a shadow copy of the timing registers and checks it word by word.
// Depends on irpde_pkg and the ir_pulse_distance_encoder RTL.
module ir_pulse_distance_encoder_tb;

    localparam int PAYLOAD_W = irpde_pkg::PAYLOAD_W;
    localparam int COUNT_W   = irpde_pkg::COUNT_W;
    localparam int DUR_W     = irpde_pkg::DUR_W;
    localparam int CFG_IDX_W = irpde_pkg::CFG_IDX_W;
    localparam int MAX_BITS  = irpde_pkg::MAX_BITS;

    // Index past the end of the register file: writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam int RANDOM_PHASES   = 8;
    localparam int FRAMES_PER_PHASE = 52;
    localparam int HOLD_AT         = 200;      // frames taken before the long hold-off
    localparam int HOLD_CYCLES     = 600;      // length of the long hold-off
    localparam int CYCLE_LIMIT     = 1000000;

    typedef struct {
        logic [PAYLOAD_W-1:0] payload;
        logic [COUNT_W-1:0]   bit_count;
    } frame_t;

    typedef struct {
        logic [DUR_W-1:0] mark_us;
        logic [DUR_W-1:0] space_us;
        logic             last_pair;
    } pair_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [DUR_W-1:0]     cfg_wdata   = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [PAYLOAD_W-1:0] s_payload   = '0;
    logic [COUNT_W-1:0]   s_bit_count = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [DUR_W-1:0]     m_mark_us;
    logic [DUR_W-1:0]     m_space_us;
    logic                 m_last_pair;

    // Shadow of the timing registers, indexed by register number.
    logic [DUR_W-1:0] timing_regs [0:6];

    frame_t frame_queue [$];      // frames waiting to be offered
    pair_t  pending_pairs [$];    // pairs owed by the block, oldest first

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int frames_taken    = 0;
    int errors          = 0;
    int cycles          = 0;
    int hold_left       = 0;
    bit hold_done       = 1'b0;

    ir_pulse_distance_encoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .s_bit_count (s_bit_count),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_mark_us   (m_mark_us),
        .m_space_us  (m_space_us),
        .m_last_pair (m_last_pair)
    );

    always #1 aclk = ~aclk;

    // Append one owed pair to the tail of the prediction queue.
    function automatic void owe_pair(logic [DUR_W-1:0] mark, logic [DUR_W-1:0] space);
        pair_t p;
        p.mark_us   = mark;
        p.space_us  = space;
        p.last_pair = 1'b0;
        pending_pairs.insert(pending_pairs.size(), p);
    endfunction

    // Work out the pairs one frame must produce: header, one pair per bit (MSB of the
    // sent bits first), optional trailer; the final pair carries the last flag.
    function automatic void encode_frame(logic [PAYLOAD_W-1:0] word, logic [COUNT_W-1:0] count);
        int                   n;
        logic [PAYLOAD_W-1:0] shifter;
        n = count;
        if (n > MAX_BITS) n = MAX_BITS;
        if (n > PAYLOAD_W) n = PAYLOAD_W;
        shifter = (n > 0) ? (word << (PAYLOAD_W - n)) : '0;
        owe_pair(timing_regs[irpde_pkg::REG_HEADER_MARK],
                 timing_regs[irpde_pkg::REG_HEADER_SPACE]);
        for (int i = 0; i < n; i++) begin
            if (shifter[PAYLOAD_W-1])
                owe_pair(timing_regs[irpde_pkg::REG_ONE_MARK],
                         timing_regs[irpde_pkg::REG_ONE_SPACE]);
            else
                owe_pair(timing_regs[irpde_pkg::REG_ZERO_MARK],
                         timing_regs[irpde_pkg::REG_ZERO_SPACE]);
            shifter = shifter << 1;
        end
        // A zero trailer mark drops the trailer pair altogether.
        if (timing_regs[irpde_pkg::REG_TRAILER_MARK] != '0)
            owe_pair(timing_regs[irpde_pkg::REG_TRAILER_MARK], '0);
        pending_pairs[pending_pairs.size()-1].last_pair = 1'b1;
    endfunction

    // Sender: offer the next frame, hold it until taken, predict on acceptance.
    always @(posedge aclk) begin
        frame_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                encode_frame(s_payload, s_bit_count);
                frames_taken <= frames_taken + 1;
            end
            if (!s_valid || s_ready) begin
                if (frame_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    nxt = frame_queue.pop_front();
                    s_payload   <= nxt.payload;
                    s_bit_count <= nxt.bit_count;
                    s_valid     <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up into its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && frames_taken >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: compare each accepted word with the oldest pending pair.
    always @(posedge aclk) begin
        pair_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pairs.size() == 0) begin
                $display("%0t unexpected pair: got mark %0d space %0d last %0d", $time,
                         m_mark_us, m_space_us, m_last_pair);
                errors++;
            end else begin
                want = pending_pairs.pop_front();
                if (m_mark_us !== want.mark_us) begin
                    $display("%0t mark_us mismatch: expected %0d got %0d", $time,
                             want.mark_us, m_mark_us);
                    errors++;
                end
                if (m_space_us !== want.space_us) begin
                    $display("%0t space_us mismatch: expected %0d got %0d", $time,
                             want.space_us, m_space_us);
                    errors++;
                end
                if (m_last_pair !== want.last_pair) begin
                    $display("%0t last_pair mismatch: expected %0d got %0d", $time,
                             want.last_pair, m_last_pair);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic void queue_frame(logic [PAYLOAD_W-1:0] word, logic [COUNT_W-1:0] count);
        frame_t f;
        f.payload   = word;
        f.bit_count = count;
        frame_queue.insert(frame_queue.size(), f);
    endfunction

    function automatic logic [PAYLOAD_W-1:0] rand_payload();
        case ($urandom_range(7))
            0:       return '1;
            1:       return '0;
            2:       return PAYLOAD_W'(1) << $urandom_range(PAYLOAD_W - 1);
            default: return PAYLOAD_W'({$urandom(), $urandom()});
        endcase
    endfunction

    // Mostly protocol-sized frames, with empty and oversized counts mixed in.
    function automatic logic [COUNT_W-1:0] rand_count();
        case ($urandom_range(7))
            0:       return '0;
            1:       return COUNT_W'($urandom_range(63, MAX_BITS + 1));
            2:       return COUNT_W'(32);
            3:       return COUNT_W'(MAX_BITS);
            default: return COUNT_W'($urandom_range(MAX_BITS, 1));
        endcase
    endfunction

    function automatic logic [DUR_W-1:0] rand_duration();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return DUR_W'($urandom());
        endcase
    endfunction

    // One register write; the shadow follows only for real registers.
    task automatic write_timing(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx <= irpde_pkg::REG_TRAILER_MARK)
            timing_regs[idx] = val;
    endtask

    // Wait until every frame is taken and every pair has come out, then let the block settle.
    task automatic drain();
        while (frame_queue.size() > 0 || s_valid || pending_pairs.size() > 0)
            @(negedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic program_timings(int setting);
        logic [DUR_W-1:0] vals [0:6];
        for (int i = 0; i < 7; i++) vals[i] = rand_duration();
        case (setting)
            0: for (int i = 0; i < 7; i++) vals[i] = '0;
            1: for (int i = 0; i < 7; i++) vals[i] = '1;
            2: vals = '{16'd2400, 16'd600, 16'd1200, 16'd600, 16'd600, 16'd600, 16'd0};
            default: if ($urandom_range(3) == 0) vals[irpde_pkg::REG_TRAILER_MARK] = '0;
        endcase
        for (int i = 0; i < 7; i++) write_timing(CFG_IDX_W'(i), vals[i]);
        // Hit the spare index too; the block must ignore it.
        if (setting == 2) write_timing(REG_SPARE, DUR_W'($urandom()));
    endtask

    initial begin
        timing_regs[irpde_pkg::REG_HEADER_MARK]  = irpde_pkg::RST_HEADER_MARK;
        timing_regs[irpde_pkg::REG_HEADER_SPACE] = irpde_pkg::RST_HEADER_SPACE;
        timing_regs[irpde_pkg::REG_ONE_MARK]     = irpde_pkg::RST_ONE_MARK;
        timing_regs[irpde_pkg::REG_ONE_SPACE]    = irpde_pkg::RST_ONE_SPACE;
        timing_regs[irpde_pkg::REG_ZERO_MARK]    = irpde_pkg::RST_ZERO_MARK;
        timing_regs[irpde_pkg::REG_ZERO_SPACE]   = irpde_pkg::RST_ZERO_SPACE;
        timing_regs[irpde_pkg::REG_TRAILER_MARK] = irpde_pkg::RST_TRAILER_MARK;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed frames on the reset timings: empty, single bit, full width,
        // oversized counts, alternating patterns and bits above the count.
        queue_frame('1, 6'd0);
        queue_frame('0, 6'd0);
        queue_frame(48'd1, 6'd1);
        queue_frame(48'd0, 6'd1);
        queue_frame('1, 6'd48);
        queue_frame('0, 6'd48);
        queue_frame(48'hAAAA_AAAA_AAAA, 6'd48);
        queue_frame(48'h5555_5555_5555, 6'd48);
        queue_frame(48'h8000_0000_0000, 6'd48);
        queue_frame(48'h8000_0000_0000, 6'd47);
        queue_frame(48'h0000_00FF_20DF, 6'd32);
        queue_frame(48'h4004_0100_BCBD, 6'd48);
        queue_frame('1, 6'd49);
        queue_frame(48'h1234_5678_9ABC, 6'd63);
        queue_frame(48'hFFFF_FFFF_FFFE, 6'd12);
        queue_frame(48'h0000_0000_0A90, 6'd20);
        drain();

        for (int p = 1; p <= RANDOM_PHASES; p++) begin
            program_timings(p - 1);
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin sender_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            // With everything zero the trailer is off: the header alone ends an empty frame.
            if (p == 1) begin
                queue_frame('1, 6'd0);
                queue_frame('1, 6'd48);
                queue_frame(48'h0F0F_0F0F_0F0F, 6'd5);
            end
            for (int i = 0; i < FRAMES_PER_PHASE; i++)
                queue_frame(rand_payload(), rand_count());
            drain();
        end

        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
